// ===== hdl/rbsi_pkg.sv =====
// Shared types and constants for the ray versus box slab intersection block.
// Used by every module under hdl; depends on nothing else.
package rbsi_pkg;

   // Field and datapath widths.
   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   localparam int DV_W    = 32;               // divisor magnitude
   localparam int REM_W   = 32;               // partial remainder
   localparam int NQ_W    = COORD_W + 1 + FRAC_W;  // numerator / quotient magnitude
   localparam int BND_W   = NQ_W + 1;         // signed slab bound
   localparam int AXES    = 3;
   localparam int LANES   = 2 * AXES;         // near and far bound per axis

   // Distance reported on a miss: -1.0 in Q16.16.
   localparam logic [COORD_W-1:0] MISS_VALUE = 32'hFFFF_0000;
   localparam logic [COORD_W-1:0] SAT_MAX    = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_MIN    = 32'h8000_0000;

   typedef logic signed [BND_W-1:0] bnd_type;

   // Bounds of an unbounded slab; both lie beyond any computed bound.
   localparam bnd_type BND_LOW  = {1'b1, {(BND_W-1){1'b0}}};
   localparam bnd_type BND_HIGH = {1'b0, {(BND_W-1){1'b1}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] dir_x;
      logic signed [COORD_W-1:0] dir_y;
      logic signed [COORD_W-1:0] dir_z;
      logic signed [COORD_W-1:0] box_min_x;
      logic signed [COORD_W-1:0] box_min_y;
      logic signed [COORD_W-1:0] box_min_z;
      logic signed [COORD_W-1:0] box_max_x;
      logic signed [COORD_W-1:0] box_max_y;
      logic signed [COORD_W-1:0] box_max_z;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] entry_distance;
   } rsp_type;

   // One divider lane: remainder, numerator bits shifted out as quotient
   // bits shift in, and the divisor magnitude.
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [NQ_W-1:0]  nq;
      logic [DV_W-1:0]  dv;
   } lane_type;

   // Per-item flags that travel alongside the divider lanes.
   typedef struct packed {
      logic [AXES-1:0]  zero;     // direction component is zero
      logic [AXES-1:0]  outside;  // origin outside slab (zero direction only)
      logic [LANES-1:0] neg;      // quotient of the lane is negative
   } side_type;

endpackage

// ===== hdl/rbsi_prep.sv =====
// Operand preparation: picks near and far corners and forms unsigned magnitudes.
// Depends on rbsi_pkg.
module rbsi_prep (
   input  rbsi_pkg::req_type                     req_word,
   output rbsi_pkg::lane_type [rbsi_pkg::LANES-1:0] lanes,
   output rbsi_pkg::side_type                    side
);

   logic signed [rbsi_pkg::COORD_W-1:0] org [rbsi_pkg::AXES];
   logic signed [rbsi_pkg::COORD_W-1:0] dir [rbsi_pkg::AXES];
   logic signed [rbsi_pkg::COORD_W-1:0] bmn [rbsi_pkg::AXES];
   logic signed [rbsi_pkg::COORD_W-1:0] bmx [rbsi_pkg::AXES];

   assign org[0] = req_word.origin_x;
   assign org[1] = req_word.origin_y;
   assign org[2] = req_word.origin_z;
   assign dir[0] = req_word.dir_x;
   assign dir[1] = req_word.dir_y;
   assign dir[2] = req_word.dir_z;
   assign bmn[0] = req_word.box_min_x;
   assign bmn[1] = req_word.box_min_y;
   assign bmn[2] = req_word.box_min_z;
   assign bmx[0] = req_word.box_max_x;
   assign bmx[1] = req_word.box_max_y;
   assign bmx[2] = req_word.box_max_z;

   // Each axis feeds two lanes: the entry bound and the exit bound.
   always_comb begin
      logic                                dneg;
      logic [rbsi_pkg::DV_W-1:0]           dmag;
      logic signed [rbsi_pkg::COORD_W-1:0] corner;
      logic signed [rbsi_pkg::COORD_W:0]   diff;
      logic [rbsi_pkg::COORD_W:0]          mag;
      side = '0;
      lanes = '0;
      for (int a = 0; a < rbsi_pkg::AXES; a++) begin
         dneg = dir[a][rbsi_pkg::COORD_W-1];
         dmag = dneg ? rbsi_pkg::DV_W'(-dir[a]) : rbsi_pkg::DV_W'(dir[a]);
         side.zero[a]    = (dir[a] == '0);
         side.outside[a] = (org[a] < bmn[a]) || (org[a] > bmx[a]);
         for (int f = 0; f < 2; f++) begin
            // A negative direction swaps which corner is entered first.
            corner = ((f == 0) ^ dneg) ? bmn[a] : bmx[a];
            diff = {corner[rbsi_pkg::COORD_W-1], corner}
                 - {org[a][rbsi_pkg::COORD_W-1], org[a]};
            mag = diff[rbsi_pkg::COORD_W] ? (rbsi_pkg::COORD_W+1)'(-diff)
                                          : (rbsi_pkg::COORD_W+1)'(diff);
            lanes[2*a+f].rem = '0;
            lanes[2*a+f].nq  = {mag, {rbsi_pkg::FRAC_W{1'b0}}};
            lanes[2*a+f].dv  = dmag;
            side.neg[2*a+f]  = diff[rbsi_pkg::COORD_W] ^ dneg;
         end
      end
   end

endmodule

// ===== hdl/rbsi_div_cell.sv =====
// One restoring division step for all six lanes: produces one quotient bit each.
// Depends on rbsi_pkg; instantiated in a chain by the top level.
module rbsi_div_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   valid_in,
   input  rbsi_pkg::side_type                     side_in,
   input  rbsi_pkg::lane_type [rbsi_pkg::LANES-1:0] lanes_in,
   output logic                                   valid_ff,
   output rbsi_pkg::side_type                     side_ff,
   output rbsi_pkg::lane_type [rbsi_pkg::LANES-1:0] lanes_ff
);

   rbsi_pkg::lane_type [rbsi_pkg::LANES-1:0] lanes_in_n;

   // Shift in the next numerator bit, subtract the divisor when it fits.
   always_comb begin
      logic [rbsi_pkg::REM_W:0] trial;
      logic                     fits;
      for (int l = 0; l < rbsi_pkg::LANES; l++) begin
         trial = {lanes_in[l].rem, lanes_in[l].nq[rbsi_pkg::NQ_W-1]};
         fits  = (trial >= {1'b0, lanes_in[l].dv});
         lanes_in_n[l].rem = fits ? rbsi_pkg::REM_W'(trial - {1'b0, lanes_in[l].dv})
                                  : trial[rbsi_pkg::REM_W-1:0];
         lanes_in_n[l].nq  = {lanes_in[l].nq[rbsi_pkg::NQ_W-2:0], fits};
         lanes_in_n[l].dv  = lanes_in[l].dv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff  <= side_in;
         lanes_ff <= lanes_in_n;
      end
   end

endmodule

// ===== hdl/rbsi_reduce.sv =====
// Turns quotients into signed slab bounds, tests overlap and takes the entry bound.
// Depends on rbsi_pkg; two register stages.
module rbsi_reduce (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   valid_in,
   input  rbsi_pkg::side_type                     side_in,
   input  rbsi_pkg::lane_type [rbsi_pkg::LANES-1:0] lanes_in,
   output logic                                   valid_ff,
   output logic                                   hit_ff,
   output rbsi_pkg::bnd_type                      entry_ff
);

   logic              valid_a_ff;
   logic              miss_a_ff;
   rbsi_pkg::bnd_type bnd_a_ff [rbsi_pkg::LANES];
   rbsi_pkg::bnd_type bnd_a_in [rbsi_pkg::LANES];
   logic              miss_a_in;
   logic              hit_in;
   rbsi_pkg::bnd_type entry_in;

   // Apply the sign; a zero direction gives an unbounded slab.
   always_comb begin
      rbsi_pkg::bnd_type m;
      miss_a_in = 1'b0;
      for (int l = 0; l < rbsi_pkg::LANES; l++) begin
         m = rbsi_pkg::bnd_type'({1'b0, lanes_in[l].nq});
         if (side_in.zero[l/2]) begin
            bnd_a_in[l] = (l % 2 == 0) ? rbsi_pkg::BND_LOW : rbsi_pkg::BND_HIGH;
         end else begin
            bnd_a_in[l] = side_in.neg[l] ? -m : m;
         end
      end
      for (int a = 0; a < rbsi_pkg::AXES; a++) begin
         miss_a_in |= side_in.zero[a] & side_in.outside[a];
      end
   end

   // Every entry bound must not pass the exit bound of another axis.
   always_comb begin
      rbsi_pkg::bnd_type e01;
      logic              ok;
      ok = 1'b1;
      for (int i = 0; i < rbsi_pkg::AXES; i++) begin
         for (int j = 0; j < rbsi_pkg::AXES; j++) begin
            if (i != j && bnd_a_ff[2*i] > bnd_a_ff[2*j+1]) begin
               ok = 1'b0;
            end
         end
      end
      e01 = (bnd_a_ff[0] > bnd_a_ff[2]) ? bnd_a_ff[0] : bnd_a_ff[2];
      entry_in = (e01 > bnd_a_ff[4]) ? e01 : bnd_a_ff[4];
      hit_in = ok & ~miss_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else if (en) begin
         valid_a_ff <= valid_in;
         valid_ff   <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         miss_a_ff <= miss_a_in;
         bnd_a_ff  <= bnd_a_in;
         hit_ff    <= hit_in;
         entry_ff  <= entry_in;
      end
   end

endmodule

// ===== hdl/ray_box_slab_intersect_top.sv =====
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbsi_pkg, rbsi_prep, rbsi_div_cell and rbsi_reduce.
//
// Usage: each req word carries a ray origin, a ray direction and the two box
// corners, all signed Q16.16. It is taken at a clock edge where req_valid is
// high and req_stall is low. Each req word yields exactly one rsp word,
// with hit and the entry distance (saturated Q16.16, or -1.0 on a miss).
// rsp_word is held while rsp_stall is high.
// The path from the accepting edge to rsp_valid has 52 register stages in all:
// one divider cell per quotient bit (49 cells, six lanes each), two reduce
// stages, then the output register.
// Throughput is one word per cycle while the receiver does not stall the output.
// The whole pipeline moves as one; it freezes only when a finished word sits
// in the output register and the receiver stalls it. In that cycle req_stall
// is high. Bubbles inside the pipeline are not squeezed out while it is frozen.
// Synchronous reset clears all valid bits; the block takes words in the
// first cycle after reset is released.
module ray_box_slab_intersect_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rbsi_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rbsi_pkg::rsp_type rsp_word
);

   localparam int STAGES = rbsi_pkg::NQ_W;

   logic                                       en;
   rbsi_pkg::lane_type [rbsi_pkg::LANES-1:0]   chain_lanes [STAGES+1];
   rbsi_pkg::side_type                         chain_side  [STAGES+1];
   logic [STAGES:0]                            chain_valid;
   logic                                       red_valid;
   logic                                       red_hit;
   rbsi_pkg::bnd_type                          red_entry;
   logic                                       rsp_valid_ff;
   rbsi_pkg::rsp_type                          rsp_word_ff;
   rbsi_pkg::rsp_type                          rsp_word_in;

   // The pipeline advances unless the output word is held by the receiver.
   assign en        = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~en;

   assign chain_valid[0] = req_valid;

   rbsi_prep u_prep (
      .req_word (req_word),
      .lanes    (chain_lanes[0]),
      .side     (chain_side[0])
   );

   // Divider chain: one quotient bit per cell.
   for (genvar k = 0; k < STAGES; k++) begin : g_cell
      rbsi_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .valid_in (chain_valid[k]),
         .side_in  (chain_side[k]),
         .lanes_in (chain_lanes[k]),
         .valid_ff (chain_valid[k+1]),
         .side_ff  (chain_side[k+1]),
         .lanes_ff (chain_lanes[k+1])
      );
   end

   rbsi_reduce u_reduce (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .valid_in (chain_valid[STAGES]),
      .side_in  (chain_side[STAGES]),
      .lanes_in (chain_lanes[STAGES]),
      .valid_ff (red_valid),
      .hit_ff   (red_hit),
      .entry_ff (red_entry)
   );

   // Saturate the entry bound, or report the miss value.
   always_comb begin
      rsp_word_in.hit = red_hit;
      if (!red_hit) begin
         rsp_word_in.entry_distance = rbsi_pkg::MISS_VALUE;
      end else if (red_entry > rbsi_pkg::bnd_type'($signed(rbsi_pkg::SAT_MAX))) begin
         rsp_word_in.entry_distance = rbsi_pkg::SAT_MAX;
      end else if (red_entry < rbsi_pkg::bnd_type'($signed(rbsi_pkg::SAT_MIN))) begin
         rsp_word_in.entry_distance = rbsi_pkg::SAT_MIN;
      end else begin
         rsp_word_in.entry_distance = red_entry[rbsi_pkg::COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= red_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== hdl/rbsi_checker.sv =====
// Port-level checks for the slab intersection top level, and their binding.
// Depends on rbsi_pkg and ray_box_slab_intersect_top.
module rbsi_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input rbsi_pkg::req_type req_word,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rbsi_pkg::rsp_type rsp_word
);

   // A held output word keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // A miss always carries the -1.0 distance.
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.hit |-> rsp_word.entry_distance == rbsi_pkg::MISS_VALUE)
      else $error("miss word without the miss distance");

   // The input side is stalled only by a held output word.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without output back pressure");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind ray_box_slab_intersect_top rbsi_checker u_rbsi_checker (.*);
